// ===== src/sbphd_pkg.sv =====
// Package with widths, constant tables and register indexes of the spectrum bar meter.
`timescale 1ns / 1ps
package sbphd_pkg;

  localparam int BANDS     = 75;
  localparam int FRAC_BITS = 16;
  localparam int MAG_W     = 8;
  localparam int BAND_W    = 7;
  localparam int VAL_W     = MAG_W + FRAC_BITS;
  localparam int FACT_W    = FRAC_BITS + 1;
  localparam int PROD_W    = VAL_W + FACT_W;
  localparam int SEL_W     = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FALL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_ACCEL = CFG_IDX_W'(1);

  localparam logic [VAL_W-1:0] SPEED_INIT =
    VAL_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

  localparam logic [VAL_W-1:0] FALL_0 = VAL_W'(((64'd34 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [VAL_W-1:0] FALL_1 = VAL_W'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd2);
  localparam logic [VAL_W-1:0] FALL_2 = VAL_W'(64'd1 << FRAC_BITS);
  localparam logic [VAL_W-1:0] FALL_3 = VAL_W'(((64'd13 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [VAL_W-1:0] FALL_4 = VAL_W'(((64'd16 << FRAC_BITS) + 64'd5) / 64'd10);

  localparam logic [FACT_W-1:0] ACCEL_0 = FACT_W'(((64'd12 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [FACT_W-1:0] ACCEL_1 = FACT_W'(((64'd13 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [FACT_W-1:0] ACCEL_2 = FACT_W'(((64'd14 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [FACT_W-1:0] ACCEL_3 = FACT_W'(((64'd15 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [FACT_W-1:0] ACCEL_4 = FACT_W'(((64'd16 << FRAC_BITS) + 64'd5) / 64'd10);

  function automatic logic [VAL_W-1:0] level_fall(input logic [SEL_W-1:0] sel);
    logic [VAL_W-1:0] val;
    case (sel)
      3'd0:    val = FALL_0;
      3'd1:    val = FALL_1;
      3'd2:    val = FALL_2;
      3'd3:    val = FALL_3;
      default: val = FALL_4;
    endcase
    return val;
  endfunction

  function automatic logic [FACT_W-1:0] peak_accel(input logic [SEL_W-1:0] sel);
    logic [FACT_W-1:0] val;
    case (sel)
      3'd0:    val = ACCEL_0;
      3'd1:    val = ACCEL_1;
      3'd2:    val = ACCEL_2;
      3'd3:    val = ACCEL_3;
      default: val = ACCEL_4;
    endcase
    return val;
  endfunction

endpackage

// ===== src/spectrum_bar_peak_hold_decay_unit.sv =====
// Spectrum bar meter with per-band level, peak hold and accelerating peak fall.
//
//   channel  | ports                                         | direction
//   input    | in_valid, in_stall, in_cmd, in_band, in_magnitude | in, stall out
//   result   | out_valid, out_stall, out_band_out, out_level_out, out_peak_out | out
//   config   | cfg_wr_en, cfg_index, cfg_data                | in
//
// One transfer is taken every cycle unless a result is stalled; a result passes
// the s1, s2 and write-back registers. Band state lives in one synchronous memory
// read at acceptance, written back from s2; in-flight same-band items are forwarded.
// Reset clears per-band valid bits at once, so there is no clearing pass.
// A stalled result freezes the whole pipeline and holds off the input.
`timescale 1ns / 1ps
module spectrum_bar_peak_hold_decay_unit
  import sbphd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [BAND_W-1:0]    in_band,
  input  logic [MAG_W-1:0]     in_magnitude,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BAND_W-1:0]    out_band_out,
  output logic [VAL_W-1:0]     out_level_out,
  output logic [VAL_W-1:0]     out_peak_out,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEL_W-1:0]     cfg_data
);

  localparam logic [1:0] SPD_ZERO = 2'd0;
  localparam logic [1:0] SPD_INIT = 2'd1;
  localparam logic [1:0] SPD_KEEP = 2'd2;
  localparam logic [1:0] SPD_MUL  = 2'd3;

  logic [SEL_W-1:0] lfall_sel_r, accel_sel_r;

  logic [3*VAL_W-1:0] mem [BANDS];
  logic [BANDS-1:0]   entry_vld_r;
  logic [3*VAL_W-1:0] rd_r;
  logic               rd_vld_r;

  logic              s1_vld_r, s1_cmd_r;
  logic [BAND_W-1:0] s1_band_r;
  logic [MAG_W-1:0]  s1_mag_r;

  logic              s2_vld_r;
  logic [BAND_W-1:0] s2_band_r;
  logic [VAL_W-1:0]  s2_lvl_r, s2_pk_r, s2_spd_r;
  logic [1:0]        s2_code_r;
  logic [PROD_W-1:0] s2_prod_r;

  logic              wb_vld_r;
  logic [BAND_W-1:0] wb_band_r;
  logic [VAL_W-1:0]  wb_lvl_r, wb_pk_r, wb_spd_r;
  logic              out_valid_r;

  logic              adv;
  logic [VAL_W-1:0]  spd_fin;
  logic [VAL_W-1:0]  cur_lvl, cur_pk, cur_spd, mag_q, lvl_dec, pk_sub;
  logic [VAL_W-1:0]  s2_lvl_nxt, s2_pk_nxt;
  logic [1:0]        s2_code_nxt;
  logic [PROD_W-1:0] s2_prod_nxt;
  logic              decay;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfall_sel_r <= '0;
      accel_sel_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_LEVEL_FALL) begin
        lfall_sel_r <= cfg_data;
      end
      if (cfg_index == CFG_PEAK_ACCEL) begin
        accel_sel_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s2_vld_r) begin
        mem[s2_band_r] <= {s2_lvl_r, s2_pk_r, spd_fin};
      end
      rd_r <= mem[in_band];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      rd_vld_r    <= 1'b0;
    end else if (adv) begin
      if (s2_vld_r) begin
        entry_vld_r[s2_band_r] <= 1'b1;
      end
      rd_vld_r <= entry_vld_r[in_band];
    end
  end

  always_comb begin
    if (s2_prod_r[PROD_W-1]) begin
      spd_fin = '1;
    end else begin
      spd_fin = s2_prod_r[FRAC_BITS +: VAL_W];
    end
    unique case (s2_code_r)
      SPD_ZERO: spd_fin = '0;
      SPD_INIT: spd_fin = SPEED_INIT;
      SPD_KEEP: spd_fin = s2_spd_r;
      SPD_MUL:  spd_fin = spd_fin;
      default:  spd_fin = '0;
    endcase
  end

  always_comb begin
    if (s2_vld_r && s2_band_r == s1_band_r) begin
      cur_lvl = s2_lvl_r;
      cur_pk  = s2_pk_r;
      cur_spd = spd_fin;
    end else if (wb_vld_r && wb_band_r == s1_band_r) begin
      cur_lvl = wb_lvl_r;
      cur_pk  = wb_pk_r;
      cur_spd = wb_spd_r;
    end else if (rd_vld_r) begin
      {cur_lvl, cur_pk, cur_spd} = rd_r;
    end else begin
      cur_lvl = '0;
      cur_pk  = '0;
      cur_spd = '0;
    end

    mag_q   = {s1_mag_r, {FRAC_BITS{1'b0}}};
    lvl_dec = (cur_lvl > level_fall(lfall_sel_r)) ? cur_lvl - level_fall(lfall_sel_r) : '0;
    pk_sub  = (cur_pk > cur_spd) ? cur_pk - cur_spd : '0;
    s2_prod_nxt = PROD_W'(cur_spd) * PROD_W'(peak_accel(accel_sel_r)) + ROUND_HALF;

    decay = 1'b0;
    s2_pk_nxt   = cur_pk;
    s2_code_nxt = SPD_KEEP;
    if (s1_cmd_r) begin
      s2_lvl_nxt  = '0;
      s2_pk_nxt   = '0;
      s2_code_nxt = SPD_ZERO;
    end else if (mag_q > cur_lvl) begin
      s2_lvl_nxt = mag_q;
      if (mag_q > cur_pk) begin
        s2_pk_nxt   = mag_q;
        s2_code_nxt = SPD_INIT;
      end else begin
        decay = 1'b1;
      end
    end else begin
      s2_lvl_nxt = lvl_dec;
      decay      = 1'b1;
    end

    if (decay && cur_pk != '0) begin
      s2_pk_nxt   = (pk_sub < s2_lvl_nxt) ? s2_lvl_nxt : pk_sub;
      s2_code_nxt = SPD_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_valid && (in_band < BAND_W'(BANDS));
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r;
      if (s2_vld_r) begin
        wb_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r  <= in_cmd;
      s1_band_r <= in_band;
      s1_mag_r  <= in_magnitude;
      s2_band_r <= s1_band_r;
      s2_lvl_r  <= s2_lvl_nxt;
      s2_pk_r   <= s2_pk_nxt;
      s2_spd_r  <= cur_spd;
      s2_code_r <= s2_code_nxt;
      s2_prod_r <= s2_prod_nxt;
      if (s2_vld_r) begin
        wb_band_r <= s2_band_r;
        wb_lvl_r  <= s2_lvl_r;
        wb_pk_r   <= s2_pk_r;
        wb_spd_r  <= spd_fin;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_band_out  = wb_band_r;
  assign out_level_out = wb_lvl_r;
  assign out_peak_out  = wb_pk_r;

  a_peak_not_below_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_out >= out_level_out)
    else $error("held peak below level");

  a_band_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_band_out < BAND_W'(BANDS))
    else $error("result for a band out of range");

  a_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_out <= {{MAG_W{1'b1}}, {FRAC_BITS{1'b0}}})
    else $error("level above largest magnitude");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && s2_vld_r) |=> s2_vld_r && $stable(s2_band_r))
    else $error("pipeline moved while result stalled");

endmodule
